/* design/rrts_pkg.sv */
package rrts_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 8;
  localparam int REM_W   = 24;
  localparam int TIME_W  = 32;
  localparam int Q_W     = 16;
  localparam int MET_W   = 16;
  localparam int SW_W    = 32;
  localparam int ENTRY_W = ID_W + REM_W + TIME_W;

  localparam logic [Q_W-1:0] QUANTUM_RESET = 16'd50;

  localparam int  PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_QUANTUM = 3'd0;

  localparam logic OP_ARRIVE   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic arrive;    // push arriving job, advance clock
    logic dispatch;  // requeue held job, count switch
    logic exec;      // pop head, run slice, emit result
  } ctrl_cmd_t;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

/* design/rrts_ctrl.sv */
module rrts_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               in_opcode,
  output logic               busy,
  output rrts_pkg::ctrl_cmd_t cmd
);

  rrts_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (start && (in_opcode == rrts_pkg::OP_DISPATCH)) begin
          state_nxt = rrts_pkg::ST_READ;
        end
      end
      rrts_pkg::ST_READ: begin
        state_nxt = rrts_pkg::ST_EXEC;
      end
      rrts_pkg::ST_EXEC: begin
        state_nxt = rrts_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rrts_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    cmd.arrive   = 1'b0;
    cmd.dispatch = 1'b0;
    cmd.exec     = 1'b0;
    case (state_r)
      rrts_pkg::ST_IDLE: begin
        busy         = 1'b0;
        cmd.arrive   = start && (in_opcode == rrts_pkg::OP_ARRIVE);
        cmd.dispatch = start && (in_opcode == rrts_pkg::OP_DISPATCH);
      end
      rrts_pkg::ST_READ: begin
        busy = 1'b1;
      end
      rrts_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

/* design/rrts_dp.sv */
module rrts_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrts_pkg::ctrl_cmd_t           cmd,
  input  logic [rrts_pkg::Q_W-1:0]      quantum,
  input  logic [rrts_pkg::ID_W-1:0]     in_job_id,
  input  logic [rrts_pkg::TIME_W-1:0]   in_arrival_time,
  input  logic [rrts_pkg::REM_W-1:0]    in_burst_time,
  input  logic [rrts_pkg::TIME_W-1:0]   in_deadline,
  output logic                          out_valid,
  output logic                          out_idle,
  output logic [rrts_pkg::ID_W-1:0]     out_ran_id,
  output logic [rrts_pkg::Q_W-1:0]      out_slice_time,
  output logic                          out_completed,
  output logic                          out_on_time,
  output logic [rrts_pkg::TIME_W-1:0]   out_now_time,
  output logic [rrts_pkg::MET_W-1:0]    out_on_time_count,
  output logic [rrts_pkg::SW_W-1:0]     out_switch_count,
  output logic                          out_overflow
);

  // job queue storage: {id, remaining, deadline}
  logic [rrts_pkg::ENTRY_W-1:0] mem [rrts_pkg::QUEUE_DEPTH];
  logic [rrts_pkg::ENTRY_W-1:0] rd_data_r;

  logic [rrts_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [rrts_pkg::PTR_W-1:0]  tail_r, tail_nxt;
  logic [rrts_pkg::OCC_W-1:0]  occ_r, occ_nxt;
  logic [rrts_pkg::TIME_W-1:0] clock_r, clock_nxt;
  logic                        held_valid_r, held_valid_nxt;
  logic [rrts_pkg::ENTRY_W-1:0] held_r, held_nxt;
  logic                        any_ran_r, any_ran_nxt;
  logic [rrts_pkg::MET_W-1:0]  met_r, met_nxt;
  logic [rrts_pkg::SW_W-1:0]   sw_r, sw_nxt;
  logic                        ovf_r, ovf_nxt;

  logic                        out_valid_r, out_idle_r, out_completed_r, out_on_time_r;
  logic [rrts_pkg::ID_W-1:0]   out_ran_id_r;
  logic [rrts_pkg::Q_W-1:0]    out_slice_r;
  logic [rrts_pkg::TIME_W-1:0] out_now_r;
  logic [rrts_pkg::MET_W-1:0]  out_met_r;
  logic [rrts_pkg::SW_W-1:0]   out_sw_r;
  logic                        out_ovf_r;

  logic                         full;
  logic                         wr_en;
  logic [rrts_pkg::ENTRY_W-1:0] wr_data;

  logic [rrts_pkg::ID_W-1:0]   hd_id;
  logic [rrts_pkg::REM_W-1:0]  hd_rem, rem_left;
  logic [rrts_pkg::TIME_W-1:0] hd_dl, clock_run;
  logic [rrts_pkg::Q_W-1:0]    q_eff, run;
  logic                        queue_empty, done, met;

  assign full        = (occ_r == rrts_pkg::OCC_W'(rrts_pkg::QUEUE_DEPTH));
  assign queue_empty = (occ_r == '0);

  assign wr_en   = (cmd.arrive || (cmd.dispatch && held_valid_r)) && !full;
  assign wr_data = cmd.arrive ? {in_job_id, in_burst_time, in_deadline} : held_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_r] <= wr_data;
    end
    rd_data_r <= mem[head_r];
  end

  // slice arithmetic on the head entry
  assign hd_id  = rd_data_r[rrts_pkg::ENTRY_W-1 -: rrts_pkg::ID_W];
  assign hd_rem = rd_data_r[rrts_pkg::TIME_W +: rrts_pkg::REM_W];
  assign hd_dl  = rd_data_r[rrts_pkg::TIME_W-1:0];

  assign q_eff     = (quantum == '0) ? rrts_pkg::Q_W'(1) : quantum;
  assign run       = (hd_rem < {8'd0, q_eff}) ? hd_rem[rrts_pkg::Q_W-1:0] : q_eff;
  assign rem_left  = hd_rem - {8'd0, run};
  assign clock_run = clock_r + {16'd0, run};
  assign done      = (rem_left == '0);
  assign met       = done && (clock_run <= hd_dl);

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    clock_nxt      = clock_r;
    held_valid_nxt = held_valid_r;
    held_nxt       = held_r;
    any_ran_nxt    = any_ran_r;
    met_nxt        = met_r;
    sw_nxt         = sw_r;
    ovf_nxt        = ovf_r;

    if (cmd.arrive) begin
      if (in_arrival_time > clock_r) begin
        clock_nxt = in_arrival_time;
      end
    end

    if (cmd.dispatch) begin
      held_valid_nxt = 1'b0;
      held_nxt       = '0;
      if (any_ran_r) begin
        sw_nxt = sw_r + rrts_pkg::SW_W'(1);
      end
    end

    if (cmd.arrive || (cmd.dispatch && held_valid_r)) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        tail_nxt = rrts_pkg::next_slot(tail_r);
        occ_nxt  = occ_r + rrts_pkg::OCC_W'(1);
      end
    end

    if (cmd.exec && !queue_empty) begin
      head_nxt    = rrts_pkg::next_slot(head_r);
      occ_nxt     = occ_r - rrts_pkg::OCC_W'(1);
      clock_nxt   = clock_run;
      any_ran_nxt = 1'b1;
      if (done) begin
        if (met && (met_r != '1)) begin
          met_nxt = met_r + rrts_pkg::MET_W'(1);
        end
      end else begin
        held_valid_nxt = 1'b1;
        held_nxt       = {hd_id, rem_left, hd_dl};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      occ_r        <= '0;
      clock_r      <= '0;
      held_valid_r <= 1'b0;
      held_r       <= '0;
      any_ran_r    <= 1'b0;
      met_r        <= '0;
      sw_r         <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      occ_r        <= occ_nxt;
      clock_r      <= clock_nxt;
      held_valid_r <= held_valid_nxt;
      held_r       <= held_nxt;
      any_ran_r    <= any_ran_nxt;
      met_r        <= met_nxt;
      sw_r         <= sw_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= cmd.exec;
    end
  end

  // result word, registered from the slice in the exec state
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_idle_r      <= queue_empty;
      out_ran_id_r    <= queue_empty ? '0 : hd_id;
      out_slice_r     <= queue_empty ? '0 : run;
      out_completed_r <= !queue_empty && done;
      out_on_time_r   <= !queue_empty && met;
      out_now_r       <= clock_nxt;
      out_met_r       <= met_nxt;
      out_sw_r        <= sw_r;
      out_ovf_r       <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_idle          = out_idle_r;
  assign out_ran_id        = out_ran_id_r;
  assign out_slice_time    = out_slice_r;
  assign out_completed     = out_completed_r;
  assign out_on_time       = out_on_time_r;
  assign out_now_time      = out_now_r;
  assign out_on_time_count = out_met_r;
  assign out_switch_count  = out_sw_r;
  assign out_overflow      = out_ovf_r;

endmodule

/* design/round_robin_time_slice_scheduler_unit.sv */
// Round-robin time-slice scheduler, fixed quantum, times in whole ms.
// Arrival word: taken in the idle state, busy stays low, no result; one per cycle while idle.
// Dispatch word: requeue write in idle, registered read of the queue head in
//   read, then the slice itself in exec; busy is high through read and exec, so
//   no new word is taken until the dispatch is through. The result is registered.
// Reset (rst_n low, synchronous): queue empty, clock and counters zero,
//   quantum 50 ms. Results are strobed for one cycle; the receiver cannot stall.
module round_robin_time_slice_scheduler_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_opcode,
  input  logic [rrts_pkg::ID_W-1:0]     in_job_id,
  input  logic [rrts_pkg::TIME_W-1:0]   in_arrival_time,
  input  logic [rrts_pkg::REM_W-1:0]    in_burst_time,
  input  logic [rrts_pkg::TIME_W-1:0]   in_deadline,
  // result channel
  output logic                          out_valid,
  output logic                          out_idle,
  output logic [rrts_pkg::ID_W-1:0]     out_ran_id,
  output logic [rrts_pkg::Q_W-1:0]      out_slice_time,
  output logic                          out_completed,
  output logic                          out_on_time,
  output logic [rrts_pkg::TIME_W-1:0]   out_now_time,
  output logic [rrts_pkg::MET_W-1:0]    out_on_time_count,
  output logic [rrts_pkg::SW_W-1:0]     out_switch_count,
  output logic                          out_overflow,
  // APB register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrts_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  rrts_pkg::ctrl_cmd_t       cmd;
  logic [rrts_pkg::Q_W-1:0]  quantum_r, quantum_nxt;
  logic                      cfg_wr;

  // Register map: 0x0 quantum (ms, low 16 bits). Zero quantum runs as 1 ms.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == rrts_pkg::ADDR_QUANTUM);

  always_comb begin
    quantum_nxt = quantum_r;
    if (cfg_wr) begin
      quantum_nxt = pwdata[rrts_pkg::Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= rrts_pkg::QUANTUM_RESET;
    end else begin
      quantum_r <= quantum_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == rrts_pkg::ADDR_QUANTUM) begin
      prdata = {16'd0, quantum_r};
    end
  end

  // sequencer: idle -> read -> exec for a dispatch; arrivals complete in idle
  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .busy      (busy),
    .cmd       (cmd)
  );

  // queue memory, clock, held job and counters
  rrts_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .quantum           (quantum_r),
    .in_job_id         (in_job_id),
    .in_arrival_time   (in_arrival_time),
    .in_burst_time     (in_burst_time),
    .in_deadline       (in_deadline),
    .out_valid         (out_valid),
    .out_idle          (out_idle),
    .out_ran_id        (out_ran_id),
    .out_slice_time    (out_slice_time),
    .out_completed     (out_completed),
    .out_on_time       (out_on_time),
    .out_now_time      (out_now_time),
    .out_on_time_count (out_on_time_count),
    .out_switch_count  (out_switch_count),
    .out_overflow      (out_overflow)
  );

endmodule
